/* hdl/q5k_block_dequantizer_core_macros.svh */
// Assertion macros for the Q5_K block dequantiser.
// Both take the clock and the active-low reset from the enclosing module.
`ifndef Q5K_BLOCK_DEQUANTIZER_CORE_MACROS_SVH
`define Q5K_BLOCK_DEQUANTIZER_CORE_MACROS_SVH

// A property must hold at every rising clock edge outside reset.
`define Q5K_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// A condition must never be seen outside reset.
`define Q5K_NEVER(label, cond, msg) \
    `Q5K_ASSERT(label, !(cond), msg)

`endif

/* hdl/q5k_pkg.sv */
// ----------------------------------------------------------------------------
// q5k_pkg
// Types, constants and helper functions for the Q5_K block dequantiser.
// ----------------------------------------------------------------------------
package q5k_pkg;

    localparam logic [7:0] POS_SCALE_LO = 8'd0;
    localparam logic [7:0] POS_SCALE_HI = 8'd1;
    localparam logic [7:0] POS_MIN_LO   = 8'd2;
    localparam logic [7:0] POS_MIN_HI   = 8'd3;
    localparam logic [7:0] SCALES_AT    = 8'd4;
    localparam logic [7:0] HIGH_AT      = 8'd16;
    localparam logic [7:0] NIBBLES_AT   = 8'd48;
    localparam logic [7:0] LAST_POS     = 8'd175;

    localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
    localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DD,
        ST_MM,
        ST_PROD,
        ST_SUB,
        ST_ERR
    } q5k_state_t;

    typedef enum logic {
        FOP_MUL,
        FOP_SUB
    } q5k_fop_t;

    typedef struct packed {
        logic [15:0]      d_half;
        logic [15:0]      dmin_half;
        logic [11:0][7:0] scales;
        logic [7:0]       hb_byte;
        logic [7:0]       nib_byte;
    } q5k_rd_t;

    // Exact widening of an fp16 pattern to fp32.
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [3:0]  s;
        logic [10:0] sh;
        logic [7:0]  e;
        logic [31:0] bits;
        ex  = h[14:10];
        man = h[9:0];
        s   = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) begin
                s = 4'(10 - i);
            end
        end
        sh = {1'b0, man} << s;
        e  = 8'd113 - {4'd0, s};
        if (ex == 5'd0) begin
            if (man == 10'd0) begin
                bits = {h[15], 31'd0};
            end else begin
                bits = {h[15], e, sh[9:0], 13'd0};
            end
        end else if (ex == 5'h1F) begin
            bits = {h[15], 8'hFF, man, 13'd0};
        end else begin
            bits = {h[15], 8'({3'd0, ex} + 8'd112), man, 13'd0};
        end
        return bits;
    endfunction

    // Small unsigned integer to fp32, always exact.
    function automatic logic [31:0] u6_to_single(input logic [5:0] v);
        logic [2:0]  p;
        logic [28:0] tmp;
        p = 3'd0;
        for (int i = 0; i < 6; i++) begin
            if (v[i]) begin
                p = 3'(i);
            end
        end
        tmp = {v, 23'd0} >> p;
        if (v == 6'd0) begin
            return 32'd0;
        end
        return {1'b0, 8'd127 + {5'd0, p}, tmp[22:0]};
    endfunction

    // 6-bit scale and min of sub-block k, returned as {sc, mn}.
    function automatic logic [11:0] unpack_scale_min(input logic [11:0][7:0] q,
                                                     input logic [2:0] k);
        logic [3:0] kk;
        kk = {1'b0, k};
        if (!k[2]) begin
            return {q[kk][5:0], q[kk + 4'd4][5:0]};
        end
        return {q[kk - 4'd4][7:6], q[kk + 4'd4][3:0], q[kk][7:6], q[kk + 4'd4][7:4]};
    endfunction

    // Leading zeros of a non-zero 27-bit word.
    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] lz;
        lz = 5'd0;
        for (int i = 0; i < 27; i++) begin
            if (v[i]) begin
                lz = 5'(26 - i);
            end
        end
        return lz;
    endfunction

endpackage

/* hdl/q5k_store.sv */
// ----------------------------------------------------------------------------
// q5k_store
// Block header, high-bit bytes and the current nibble group, byte-addressed.
// ----------------------------------------------------------------------------
module q5k_store
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [7:0]           wr_pos,
    input  logic [7:0]           wr_byte,
    input  logic [4:0]           rd_idx,
    output q5k_pkg::q5k_rd_t     rd
);
    import q5k_pkg::*;

    logic [15:0]      d_half_reg;
    logic [15:0]      dmin_half_reg;
    logic [11:0][7:0] scales_reg;
    logic [7:0]       hb_mem [32];
    logic [7:0]       nib_mem [32];
    logic [7:0]       hb_rd_reg;
    logic [7:0]       nib_rd_reg;
    logic [7:0]       off_sc;
    logic [7:0]       off_hb;
    logic [7:0]       off_nb;

    assign off_sc = wr_pos - SCALES_AT;
    assign off_hb = wr_pos - HIGH_AT;
    assign off_nb = wr_pos - NIBBLES_AT;

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            priority if (wr_pos == POS_SCALE_LO) begin
                d_half_reg[7:0] <= wr_byte;
            end else if (wr_pos == POS_SCALE_HI) begin
                d_half_reg[15:8] <= wr_byte;
            end else if (wr_pos == POS_MIN_LO) begin
                dmin_half_reg[7:0] <= wr_byte;
            end else if (wr_pos == POS_MIN_HI) begin
                dmin_half_reg[15:8] <= wr_byte;
            end else if (wr_pos < HIGH_AT) begin
                scales_reg[off_sc[3:0]] <= wr_byte;
            end else if (wr_pos < NIBBLES_AT) begin
                hb_mem[off_hb[4:0]] <= wr_byte;
            end else begin
                nib_mem[off_nb[4:0]] <= wr_byte;
            end
        end
        // registered read: rd_idx is the nibble-byte index within the group of the next cycle
        hb_rd_reg  <= hb_mem[rd_idx];
        nib_rd_reg <= nib_mem[rd_idx];
    end

    always_comb
    begin
        rd.d_half    = d_half_reg;
        rd.dmin_half = dmin_half_reg;
        rd.scales    = scales_reg;
        rd.hb_byte   = hb_rd_reg;
        rd.nib_byte  = nib_rd_reg;
    end

endmodule

/* hdl/q5k_fpu.sv */
// ----------------------------------------------------------------------------
// q5k_fpu
// Shared single-precision unit: multiply or subtract, round to nearest even.
// ----------------------------------------------------------------------------
module q5k_fpu
(
    input  q5k_pkg::q5k_fop_t op,
    input  logic [31:0]       a,
    input  logic [31:0]       b,
    output logic [31:0]       y
);
    import q5k_pkg::*;

    logic        sa, sb;
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

    logic [47:0] prod;
    logic [23:0] pm;
    logic        pg, pst, pinc;
    logic [24:0] pr;
    logic [9:0]  pe;
    logic [31:0] mul_y;

    logic        swap, sx, sub_eff;
    logic [7:0]  ex, ey, diff;
    logic [26:0] mx, my;
    logic [53:0] ysh;
    logic [26:0] yal;
    logic [27:0] sum;
    logic [26:0] nrm;
    logic [4:0]  lz;
    logic [9:0]  se;
    logic        ainc;
    logic [24:0] ar;
    logic [31:0] sub_y;

    assign sa = a[31];
    assign sb = b[31];
    assign ea = a[30:23];
    assign eb = b[30:23];
    assign fa = a[22:0];
    assign fb = b[22:0];
    assign a_nan  = (ea == 8'hFF) && (fa != 23'd0);
    assign b_nan  = (eb == 8'hFF) && (fb != 23'd0);
    assign a_inf  = (ea == 8'hFF) && (fa == 23'd0);
    assign b_inf  = (eb == 8'hFF) && (fb == 23'd0);
    assign a_zero = (ea == 8'd0);
    assign b_zero = (eb == 8'd0);

    // multiply
    always_comb
    begin
        prod = {1'b1, fa} * {1'b1, fb};
        if (prod[47]) begin
            pm  = prod[47:24];
            pg  = prod[23];
            pst = |prod[22:0];
            pe  = {2'd0, ea} + {2'd0, eb} - 10'd126;
        end else begin
            pm  = prod[46:23];
            pg  = prod[22];
            pst = |prod[21:0];
            pe  = {2'd0, ea} + {2'd0, eb} - 10'd127;
        end
        pinc = pg & (pst | pm[0]);
        pr   = {1'b0, pm} + {24'd0, pinc};
        if (pr[24]) begin
            pe = pe + 10'd1;
        end
        priority if (a_nan) begin
            mul_y = a | QUIET_BIT;
        end else if (b_nan) begin
            mul_y = b | QUIET_BIT;
        end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
            mul_y = QNAN_DEFAULT;
        end else if (a_inf || b_inf) begin
            mul_y = {sa ^ sb, 8'hFF, 23'd0};
        end else if (a_zero || b_zero) begin
            mul_y = {sa ^ sb, 31'd0};
        end else begin
            mul_y = {sa ^ sb, pe[7:0], pr[24] ? pr[23:1] : pr[22:0]};
        end
    end

    // subtract a - b as a + (-b)
    always_comb
    begin
        swap    = {eb, fb} > {ea, fa};
        sx      = swap ? ~sb : sa;
        sub_eff = sa == sb;
        ex      = swap ? eb : ea;
        ey      = swap ? ea : eb;
        mx      = swap ? {1'b1, fb, 3'd0} : {1'b1, fa, 3'd0};
        my      = swap ? {1'b1, fa, 3'd0} : {1'b1, fb, 3'd0};
        diff    = ex - ey;
        ysh     = {my, 27'd0} >> ((diff > 8'd31) ? 8'd31 : diff);
        yal     = {ysh[53:28], ysh[27] | (|ysh[26:0])};
        if (sub_eff) begin
            sum = {1'b0, mx} - {1'b0, yal};
        end else begin
            sum = {1'b0, mx} + {1'b0, yal};
        end
        lz = lzc27(sum[26:0]);
        if (sum[27]) begin
            nrm = {sum[27:2], sum[1] | sum[0]};
            se  = {2'd0, ex} + 10'd1;
        end else begin
            nrm = sum[26:0] << lz;
            se  = {2'd0, ex} - {5'd0, lz};
        end
        ainc = nrm[2] & ((nrm[1] | nrm[0]) | nrm[3]);
        ar   = {1'b0, nrm[26:3]} + {24'd0, ainc};
        if (ar[24]) begin
            se = se + 10'd1;
        end
        priority if (a_nan) begin
            sub_y = a | QUIET_BIT;
        end else if (b_nan) begin
            sub_y = b | QUIET_BIT;
        end else if (a_inf && b_inf && (sa == sb)) begin
            sub_y = QNAN_DEFAULT;
        end else if (a_inf) begin
            sub_y = a;
        end else if (b_inf) begin
            sub_y = {~sb, b[30:0]};
        end else if (a_zero && b_zero) begin
            sub_y = {sa & ~sb, 31'd0};
        end else if (a_zero) begin
            sub_y = {~sb, b[30:0]};
        end else if (b_zero) begin
            sub_y = a;
        end else if (sum == 28'd0) begin
            sub_y = 32'd0;
        end else begin
            sub_y = {sx, se[7:0], ar[24] ? ar[23:1] : ar[22:0]};
        end
    end

    assign y = (op == FOP_MUL) ? mul_y : sub_y;

endmodule

/* hdl/q5k_block_dequantizer_core.sv */
// ----------------------------------------------------------------------------
// q5k_block_dequantizer_core
// Q5_K block dequantiser: bytes in, 64 fp32 elements out per nibble group.
// ----------------------------------------------------------------------------
// Channel  Handshake            Payload
// in       in_valid/in_ready    block_byte, stream_end
// out      out_valid/out_ready  value_bits, element_index, last_of_run,
//                               last_of_block, length_error
//
// A byte that completes no nibble group leaves the sequencer idle.
// A group-closing byte starts the sequencer, and no byte is taken until it ends: one shared fp unit
// does two scale products per sub-block, then a multiply and a subtract per element.
// A stream end inside a block gives one error transaction.
// Reset clears the sequencer and the byte position; stored bytes are not cleared.
// A stalled output holds the sequencer in its subtract step.
// ----------------------------------------------------------------------------
module q5k_block_dequantizer_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  block_byte,
    input  logic        stream_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] value_bits,
    output logic [7:0]  element_index,
    output logic        last_of_run,
    output logic        last_of_block,
    output logic        length_error
);
    import q5k_pkg::*;
    `include "q5k_block_dequantizer_core_macros.svh"

    q5k_state_t  state_reg, state_next;
    logic [7:0]  pos_reg, pos_next;
    logic [1:0]  g_reg, g_next;
    logic        half_reg, half_next;
    logic [4:0]  l_reg, l_next;
    logic [31:0] dd_reg, mm_reg, prod_reg;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] value_reg;
    logic [7:0]  index_reg;
    logic        run_reg, blk_reg, err_reg;

    logic        accept, len_err, closes_group, out_free, load_out;
    logic [7:0]  off_nb;
    q5k_rd_t     rd;
    q5k_fop_t    fop;
    logic [31:0] fa, fb, fy;
    logic [11:0] scmn;
    logic [7:0]  q_byte;
    logic [7:0]  idx;

    assign accept       = in_valid && in_ready;
    assign len_err      = stream_end && (pos_reg != LAST_POS);
    assign off_nb       = pos_reg - NIBBLES_AT;
    assign closes_group = (pos_reg >= NIBBLES_AT) && (off_nb[4:0] == 5'd31);
    assign out_free     = !out_valid_reg || out_ready;
    assign idx          = {g_reg, half_reg, l_reg};

    q5k_store u_store
    (
        .clk     (clk),
        .wr_en   (accept && !len_err),
        .wr_pos  (pos_reg),
        .wr_byte (block_byte),
        .rd_idx  (l_next),
        .rd      (rd)
    );

    q5k_fpu u_fpu
    (
        .op (fop),
        .a  (fa),
        .b  (fb),
        .y  (fy)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    if (len_err) begin
                        state_next = ST_ERR;
                    end else if (closes_group) begin
                        state_next = ST_DD;
                    end
                end
            end
            ST_DD:   state_next = ST_MM;
            ST_MM:   state_next = ST_PROD;
            ST_PROD: state_next = ST_SUB;
            ST_SUB:
            begin
                if (out_free) begin
                    if (l_reg != 5'd31) begin
                        state_next = ST_PROD;
                    end else if (!half_reg) begin
                        state_next = ST_DD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERR:
            begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready = 1'b0;
        load_out = 1'b0;
        fop      = FOP_MUL;
        fa       = prod_reg;
        fb       = mm_reg;
        scmn     = unpack_scale_min(rd.scales, {g_reg, half_reg});
        q_byte   = half_reg ? {4'd0, rd.nib_byte[7:4]} : {4'd0, rd.nib_byte[3:0]};
        q_byte[4] = rd.hb_byte[{g_reg, half_reg}];
        unique case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_DD:
            begin
                fa = half_to_single(rd.d_half);
                fb = u6_to_single(scmn[11:6]);
            end
            ST_MM:
            begin
                fa = half_to_single(rd.dmin_half);
                fb = u6_to_single(scmn[5:0]);
            end
            ST_PROD:
            begin
                fa = dd_reg;
                fb = u6_to_single(q_byte[5:0]);
            end
            ST_SUB:
            begin
                fop      = FOP_SUB;
                load_out = out_free;
            end
            ST_ERR:  load_out = out_free;
            default: in_ready = 1'b0;
        endcase
    end

    always_comb
    begin
        pos_next  = pos_reg;
        g_next    = g_reg;
        half_next = half_reg;
        l_next    = l_reg;
        if (accept) begin
            if (len_err || (pos_reg == LAST_POS)) begin
                pos_next = 8'd0;
            end else begin
                pos_next = pos_reg + 8'd1;
            end
            g_next    = off_nb[6:5];
            half_next = 1'b0;
            l_next    = 5'd0;
        end else if ((state_reg == ST_SUB) && out_free) begin
            l_next = l_reg + 5'd1;
            if (l_reg == 5'd31) begin
                half_next = 1'b1;
            end
        end
        out_valid_next = load_out || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            pos_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg    <= g_next;
        half_reg <= half_next;
        l_reg    <= l_next;
        if (state_reg == ST_DD) begin
            dd_reg <= fy;
        end
        if (state_reg == ST_MM) begin
            mm_reg <= fy;
        end
        if (state_reg == ST_PROD) begin
            prod_reg <= fy;
        end
        if (load_out) begin
            if (state_reg == ST_ERR) begin
                value_reg <= 32'd0;
                index_reg <= 8'd0;
                run_reg   <= 1'b1;
                blk_reg   <= 1'b0;
                err_reg   <= 1'b1;
            end else begin
                value_reg <= fy;
                index_reg <= idx;
                run_reg   <= half_reg && (l_reg == 5'd31);
                blk_reg   <= idx == 8'd255;
                err_reg   <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign value_bits    = value_reg;
    assign element_index = index_reg;
    assign last_of_run   = run_reg;
    assign last_of_block = blk_reg;
    assign length_error  = err_reg;

    `Q5K_NEVER(a_pos_range, pos_reg > LAST_POS, "byte position beyond block end")
    `Q5K_ASSERT(a_err_next, accept && len_err |=> state_reg == ST_ERR, "no error step")
    `Q5K_ASSERT(a_err_pos, accept && len_err |=> pos_reg == 8'd0, "position not cleared")
    `Q5K_ASSERT(a_err_run, out_valid && length_error |-> last_of_run, "error not last")
    `Q5K_ASSERT(a_err_val, out_valid && length_error |-> value_bits == 32'd0, "error value")

endmodule
